// File: hdl/assert_macros.svh
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cbid_pkg.sv
`timescale 1ns / 1ps

package cbid_pkg;

    localparam int LEN_W = 9;
    localparam int IDX_W = 8;
    localparam int CH_W  = 8;

    localparam int BUF_DEPTH_DEF = 256;
    localparam logic [LEN_W-1:0] BUF_LEN_RESET = 9'd256;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_DELETE = 2'd3
    } t_cmd;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_RDWAIT = 8'b0000_1000,
        ST_INS    = 8'b0001_0000,
        ST_SRCH   = 8'b0010_0000,
        ST_SHIFT  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

endpackage

// File: hdl/cbid_ram.sv
`timescale 1ns / 1ps

module cbid_ram #(
    parameter int DATA_W = cbid_pkg::CH_W,
    parameter int DEPTH  = cbid_pkg::BUF_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/char_buffer_insert_delete_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// channel    dir  tdata (low bit up)                  tuser
// s_axis     in   index[7:0], char_value[15:8]        cmd[1:0]
// m_axis     out  read_data[7:0], hit_index[15:8]     ok[0]
// cfg        in   buffer_length[8:0] on i_cfg_wr_data  -
//
// buffer_length is saturated to min(BUF_DEPTH, 511); the single ram port pair
//   moves one byte per cycle during the shift and search walks
// after reset a clearing pass zeroes the ram, s_axis_tready low
// one word is worked at a time; the result register lets the next word in while the
//   previous result waits on m_axis_tready

module char_buffer_insert_delete_unit #(
    parameter int BUF_DEPTH = cbid_pkg::BUF_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: buffer_length
    input  logic                       i_cfg_wr_en,
    input  logic [cbid_pkg::LEN_W-1:0] i_cfg_wr_data,
    // command words
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,  // index[7:0], char_value[15:8]
    input  logic [1:0]                 s_axis_tuser,  // cmd[1:0]
    // result words
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // read_data[7:0], hit_index[15:8]
    output logic [0:0]                 m_axis_tuser   // ok[0]
);

    localparam int LW = cbid_pkg::LEN_W;
    localparam int IW = cbid_pkg::IDX_W;
    localparam int CW = cbid_pkg::CH_W;
    localparam int AW = $clog2(BUF_DEPTH);
    // largest length the 9-bit register can ask for, capped by the store size
    localparam int LEN_CAP_I = (BUF_DEPTH < 511) ? BUF_DEPTH : 511;
    localparam logic [LW-1:0] LEN_CAP = LW'(LEN_CAP_I);
    localparam logic [AW-1:0] CLR_LAST = AW'(BUF_DEPTH - 1);

    cbid_pkg::t_state r_state, n_state;
    cbid_pkg::t_cmd   r_cmd;
    logic [IW-1:0]    r_pos;
    logic [CW-1:0]    r_ch;

    logic [LW-1:0] r_buf_len;
    logic [LW-1:0] w_len;

    // walk pointer, remaining reads, address of the read in flight
    logic [LW-1:0] r_ptr, n_ptr;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_wad, n_wad;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_clr;

    // result held until the output register is free
    logic          r_res_ok, n_res_ok;
    logic [CW-1:0] r_res_rd, n_res_rd;
    logic [IW-1:0] r_res_hit, n_res_hit;

    logic          r_m_valid;
    logic          r_m_ok;
    logic [CW-1:0] r_m_rd;
    logic [IW-1:0] r_m_hit;

    logic          w_accept;
    logic          w_load;
    logic          w_in_range;
    logic          ram_we;
    logic [LW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [LW-1:0] ram_raddr;
    logic [CW-1:0] ram_rdata;

    assign w_len      = (r_buf_len > LEN_CAP) ? LEN_CAP : r_buf_len;
    assign w_in_range = LW'(r_pos) < w_len;

    assign s_axis_tready = (r_state == cbid_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == cbid_pkg::ST_DONE) && (!r_m_valid || m_axis_tready);

    cbid_ram #(
        .DATA_W (CW),
        .DEPTH  (BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ((r_state == cbid_pkg::ST_CLEAR) ? r_clr : AW'(ram_waddr)),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(ram_raddr)),
        .o_rdata (ram_rdata)
    );

    // sequencer: one ram read and at most one ram write per cycle
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_wad     = r_wad;
        n_pend    = 1'b0;
        n_res_ok  = r_res_ok;
        n_res_rd  = r_res_rd;
        n_res_hit = r_res_hit;
        ram_we    = 1'b0;
        ram_waddr = r_wad;
        ram_wdata = ram_rdata;
        ram_raddr = r_ptr;

        unique case (r_state)
            cbid_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_clr == CLR_LAST) begin
                    n_state = cbid_pkg::ST_IDLE;
                end
            end
            cbid_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = cbid_pkg::ST_EXEC;
                end
            end
            cbid_pkg::ST_EXEC: begin
                n_res_ok  = 1'b0;
                n_res_rd  = '0;
                n_res_hit = '0;
                n_state   = cbid_pkg::ST_DONE;
                if (w_in_range) begin
                    unique case (r_cmd)
                        cbid_pkg::CMD_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = LW'(r_pos);
                            ram_wdata = r_ch;
                            n_res_ok  = 1'b1;
                        end
                        cbid_pkg::CMD_READ: begin
                            ram_raddr = LW'(r_pos);
                            n_state   = cbid_pkg::ST_RDWAIT;
                        end
                        cbid_pkg::CMD_INSERT: begin
                            // shift right from the last used byte down to index+1
                            n_ptr   = w_len - 1'b1;
                            n_cnt   = w_len - 1'b1 - LW'(r_pos);
                            n_state = cbid_pkg::ST_INS;
                        end
                        cbid_pkg::CMD_DELETE: begin
                            n_ptr   = LW'(r_pos);
                            n_cnt   = w_len - LW'(r_pos);
                            n_state = cbid_pkg::ST_SRCH;
                        end
                    endcase
                end
            end
            cbid_pkg::ST_RDWAIT: begin
                n_res_ok = 1'b1;
                n_res_rd = ram_rdata;
                n_state  = cbid_pkg::ST_DONE;
            end
            cbid_pkg::ST_INS: begin
                ram_raddr = r_ptr - 1'b1;
                if (r_pend) begin
                    ram_we = 1'b1;
                end else if (r_cnt == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = LW'(r_pos);
                    ram_wdata = r_ch;
                    n_res_ok  = 1'b1;
                    n_state   = cbid_pkg::ST_DONE;
                end
                if (r_cnt != '0) begin
                    n_pend = 1'b1;
                    n_wad  = r_ptr;
                    n_ptr  = r_ptr - 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            cbid_pkg::ST_SRCH: begin
                if (r_pend && (ram_rdata == r_ch)) begin
                    // hit: read in flight is dropped, shift left starts after it
                    n_res_hit = IW'(r_wad);
                    n_ptr     = r_wad + 1'b1;
                    n_cnt     = w_len - 1'b1 - r_wad;
                    n_state   = cbid_pkg::ST_SHIFT;
                end else if (r_cnt != '0) begin
                    n_pend = 1'b1;
                    n_wad  = r_ptr;
                    n_ptr  = r_ptr + 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                end else if (!r_pend) begin
                    n_state = cbid_pkg::ST_DONE;
                end
            end
            cbid_pkg::ST_SHIFT: begin
                if (r_pend) begin
                    ram_we = 1'b1;
                end else if (r_cnt == '0) begin
                    // vacated last byte reads as zero
                    ram_we    = 1'b1;
                    ram_waddr = w_len - 1'b1;
                    ram_wdata = '0;
                    n_res_ok  = 1'b1;
                    n_state   = cbid_pkg::ST_DONE;
                end
                if (r_cnt != '0) begin
                    n_pend = 1'b1;
                    n_wad  = r_ptr - 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            cbid_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = cbid_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cbid_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cbid_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
            r_buf_len <= cbid_pkg::BUF_LEN_RESET;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (r_state == cbid_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_buf_len <= i_cfg_wr_data;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= cbid_pkg::t_cmd'(s_axis_tuser);
            r_pos <= s_axis_tdata[IW-1:0];
            r_ch  <= s_axis_tdata[IW+CW-1:IW];
        end
        r_ptr     <= n_ptr;
        r_cnt     <= n_cnt;
        r_wad     <= n_wad;
        r_res_ok  <= n_res_ok;
        r_res_rd  <= n_res_rd;
        r_res_hit <= n_res_hit;
        if (w_load) begin
            r_m_ok  <= r_res_ok;
            r_m_rd  <= r_res_rd;
            r_m_hit <= r_res_hit;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_hit, r_m_rd};
    assign m_axis_tuser  = r_m_ok;

    // a taken word keeps the input closed while it is worked
    `ASSERT_NEXT(a_busy_after_accept, w_accept, !s_axis_tready, "input open right after accept")
    // a failed command reports no data and no position
    `ASSERT_IMPL(a_fail_clean, (r_state == cbid_pkg::ST_DONE) && !r_res_ok,
        (r_res_rd == '0) && (r_res_hit == '0), "failed command carries data")
    // delete never reports a hit ahead of its start offset
    `ASSERT_IMPL(a_hit_order, (r_state == cbid_pkg::ST_DONE) && r_res_ok &&
        (r_cmd == cbid_pkg::CMD_DELETE), r_res_hit >= r_pos, "delete hit before offset")
    // shift walks stay inside the used length
    `ASSERT_IMPL(a_ins_bound, r_state == cbid_pkg::ST_INS, r_ptr < w_len,
        "insert pointer past length")
    `ASSERT_IMPL(a_shift_bound, r_state == cbid_pkg::ST_SHIFT, r_ptr <= w_len,
        "delete pointer past length")

endmodule
